// ===== design/ring_line_buffer_core_defines.svh =====
// Assertion helpers shared by the checker files.
// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef RING_LINE_BUFFER_CORE_DEFINES_SVH
`define RING_LINE_BUFFER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rlb_pkg.sv =====
package rlb_pkg;

  localparam int CAPACITY_DEF = 256;

  // Width of the scan index, the line length and the line limit register.
  localparam int IDX_W = 7;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic [IDX_W-1:0] LIMIT_MIN   = 7'd2;
  localparam logic [IDX_W-1:0] LIMIT_MAX   = 7'd64;
  localparam logic [IDX_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    STAT_ACCEPTED = 3'd0,
    STAT_REJECTED = 3'd1,
    STAT_LINE     = 3'd2,
    STAT_FLUSH    = 3'd3,
    STAT_NONE     = 3'd4
  } stat_t;

  typedef struct packed {
    logic add_go;
    logic scan_start;
    logic rd_go;
    logic idx_inc;
    logic take_line;
    logic take_miss;
    logic emit_load;
    logic term_load;
  } rlb_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic scan_end;
    logic nl_hit;
    logic emit_end;
  } rlb_sts_t;

endpackage

// ===== design/rlb_ctrl.sv =====
module rlb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_cmd,
  output logic              in_tready,
  input  rlb_pkg::rlb_sts_t sts,
  output rlb_pkg::rlb_cmd_t cmd
);
  import rlb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN_RD  = 6'b000010,
    ST_SCAN_CHK = 6'b000100,
    ST_EMIT_RD  = 6'b001000,
    ST_EMIT_OUT = 6'b010000,
    ST_TERM     = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = sts.slot_free;
        if (in_tvalid && sts.slot_free) begin
          if (in_cmd == CMD_REMOVE) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN_RD;
          end else begin
            cmd.add_go = 1'b1;
          end
        end
      end
      ST_SCAN_RD: begin
        if (sts.scan_end) begin
          cmd.take_miss = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end else begin
          cmd.rd_go = 1'b1;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts.nl_hit) begin
          cmd.take_line = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: begin
        if (sts.emit_end) begin
          state_nxt = ST_TERM;
        end else begin
          cmd.rd_go = 1'b1;
          state_nxt = ST_EMIT_OUT;
        end
      end
      ST_EMIT_OUT: begin
        if (sts.slot_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end
      end
      ST_TERM: begin
        if (sts.slot_free) begin
          cmd.term_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/rlb_datapath.sv =====
module rlb_datapath #(
  parameter int CAPACITY = rlb_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [6:0]        cfg_data,
  input  logic [7:0]        in_tdata,
  input  rlb_pkg::rlb_cmd_t cmd,
  output rlb_pkg::rlb_sts_t sts,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [7:0]        out_tdata,
  output logic [3:0]        out_tuser,
  output logic              out_tlast
);
  import rlb_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int SW = ((PW > IDX_W) ? PW : IDX_W) + 1;
  localparam int CW = (FW > IDX_W) ? FW : IDX_W;
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

  // Pointer plus offset, wrapped once at the ring size; offset never exceeds CAPACITY.
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] ptr,
                                             input logic [SW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(ptr) + off;
    if (sum >= CAP_S) begin
      sum = sum - CAP_S;
    end
    return sum[PW-1:0];
  endfunction

  logic [7:0]       mem [CAPACITY];
  logic [7:0]       rd_data_r;
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [FW-1:0]    fill_r;
  logic [IDX_W-1:0] limit_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] n_r;
  logic             found_r;
  stat_t            stat_r;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_bv_r;
  logic             out_last_r;
  stat_t            out_stat_r;

  logic [IDX_W-1:0] lim_c;
  logic [IDX_W-1:0] lim_m1;
  logic [CW-1:0]    fill_c;
  logic [CW-1:0]    window;
  logic [IDX_W-1:0] n_flush;
  logic [SW-1:0]    consume;
  logic [PW-1:0]    rd_addr;
  logic             full;

  always_comb begin
    if (limit_r < LIMIT_MIN) begin
      lim_c = LIMIT_MIN;
    end else if (limit_r > LIMIT_MAX) begin
      lim_c = LIMIT_MAX;
    end else begin
      lim_c = limit_r;
    end
    lim_m1  = lim_c - IDX_W'(1);
    fill_c  = CW'(fill_r);
    window  = (fill_c < CW'(lim_c)) ? fill_c : CW'(lim_c);
    n_flush = (fill_c < CW'(lim_m1)) ? fill_c[IDX_W-1:0] : lim_m1;
    // A complete line also consumes its newline.
    consume = SW'(n_r) + SW'(found_r);
    rd_addr = wrap_add(rd_ptr_r, SW'(idx_r));
    full    = (fill_r == CAP_F);
  end

  assign sts.slot_free = !out_valid_r || out_tready;
  assign sts.scan_end  = (CW'(idx_r) == window);
  assign sts.nl_hit    = (rd_data_r == NEWLINE);
  assign sts.emit_end  = (idx_r == n_r);

  always_ff @(posedge clk) begin
    if (cmd.add_go && !full) begin
      mem[wr_ptr_r] <= in_tdata;
    end
    if (cmd.rd_go) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      limit_r     <= LIMIT_RESET;
      idx_r       <= '0;
      n_r         <= '0;
      found_r     <= 1'b0;
      stat_r      <= STAT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (cmd.add_go && !full) begin
        wr_ptr_r <= wrap_add(wr_ptr_r, SW'(1));
        fill_r   <= fill_r + FW'(1);
      end
      if (cmd.scan_start) begin
        idx_r <= '0;
      end
      if (cmd.idx_inc || cmd.emit_load) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.take_line) begin
        n_r     <= idx_r;
        found_r <= 1'b1;
        stat_r  <= STAT_LINE;
        idx_r   <= '0;
      end
      if (cmd.take_miss) begin
        found_r <= 1'b0;
        idx_r   <= '0;
        if (full) begin
          n_r    <= n_flush;
          stat_r <= STAT_FLUSH;
        end else begin
          n_r    <= '0;
          stat_r <= STAT_NONE;
        end
      end
      if (cmd.term_load) begin
        rd_ptr_r <= wrap_add(rd_ptr_r, consume);
        fill_r   <= fill_r - FW'(consume);
      end
      if (cmd.add_go || cmd.emit_load || cmd.term_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_go) begin
      out_byte_r <= 8'd0;
      out_bv_r   <= 1'b0;
      out_last_r <= 1'b1;
      out_stat_r <= full ? STAT_REJECTED : STAT_ACCEPTED;
    end else if (cmd.emit_load) begin
      out_byte_r <= rd_data_r;
      out_bv_r   <= 1'b1;
      out_last_r <= 1'b0;
      out_stat_r <= stat_r;
    end else if (cmd.term_load) begin
      out_byte_r <= 8'd0;
      out_bv_r   <= 1'b0;
      out_last_r <= 1'b1;
      out_stat_r <= stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_stat_r, out_bv_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== design/ring_line_buffer_core.sv =====
// Byte ring buffer that hands back newline-terminated lines. An add item (in_tuser 0) stores
// in_tdata unless the ring is full and returns one result item in the cycle after it is
// taken, so adds can follow one per cycle while the output is drained. A remove item
// (in_tuser 1) first scans the ring from the read pointer, then replays the line bytes as
// result items ending in a terminator item with tlast set. All ring reads share one memory
// read port with a registered output, so each examined byte passes through a read state and
// a check state, and each emitted byte through a read state and an output state that may
// stall on the output. The line limit must be written through the cfg port only while the
// block is idle; the block itself does not enforce it.
module ring_line_buffer_core #(
  parameter int CAPACITY = rlb_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte[7:0]
  input  logic [0:0] in_tuser,   // cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte[7:0]
  output logic [3:0] out_tuser,  // byte_valid, status[2:0]
  output logic       out_tlast,  // last
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);
  import rlb_pkg::*;

  rlb_cmd_t cmd;
  rlb_sts_t sts;

  assign cfg_ready = 1'b1;

  rlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlb_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/rlb_checker.sv =====
`include "ring_line_buffer_core_defines.svh"

module rlb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [3:0] out_tuser,
  input logic       out_tlast
);
  import rlb_pkg::*;

  `RLB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result item changed while stalled")

  `RLB_ASSERT_NOW(a_blank_zero, out_tvalid && !out_tuser[0], out_tdata == 8'd0, "result without a line byte carries nonzero data")

  `RLB_ASSERT_NOW(a_byte_in_line, out_tvalid && out_tuser[0], !out_tlast && (out_tuser[3:1] == STAT_LINE || out_tuser[3:1] == STAT_FLUSH), "line byte marked last or with a wrong status")

  `RLB_ASSERT_NOW(a_single_result, out_tvalid && (out_tuser[3:1] == STAT_ACCEPTED || out_tuser[3:1] == STAT_REJECTED || out_tuser[3:1] == STAT_NONE), out_tlast && !out_tuser[0], "single result item not marked last")

endmodule

bind ring_line_buffer_core rlb_checker u_rlb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
